// File: rtl/imu_bcc_pkg.sv
// Shared types and constants for the IMU bias calibration and correction unit.
// Depends on nothing; used by every module under rtl.
package imu_bcc_pkg;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned OFFSET_W  = 24;
    localparam int unsigned SUM_W     = 24;
    localparam int unsigned STEP_W    = 1;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned CFG_DW    = 24;
    localparam int unsigned TDATA_W   = 144;
    localparam int unsigned AXES      = 3;

    localparam logic [GAIN_W-1:0]   GAIN_X_RST   = 17'd65345;
    localparam logic [GAIN_W-1:0]   GAIN_Y_RST   = 17'd65407;
    localparam logic [GAIN_W-1:0]   GAIN_Z_RST   = 17'd64936;
    localparam logic [OFFSET_W-1:0] OFFSET_X_RST = 24'sd46216;
    localparam logic [OFFSET_W-1:0] OFFSET_Y_RST = -24'sd9883;
    localparam logic [OFFSET_W-1:0] OFFSET_Z_RST = -24'sd80697;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_GAIN_X   = 3'd1,
        REG_GAIN_Y   = 3'd2,
        REG_GAIN_Z   = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_OFFSET_Z = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        CAL_ACCUM = 2'd0,
        CAL_LOAD  = 2'd1,
        CAL_DIV   = 2'd2,
        CAL_DONE  = 2'd3
    } t_cal_state;

    typedef struct packed {
        logic                               enable;
        logic [AXES-1:0][GAIN_W-1:0]        gain;
        logic [AXES-1:0][OFFSET_W-1:0]      offset;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cal_status;

    // last field in the lowest bits
    typedef struct packed {
        logic [SAMPLE_W-1:0] gyro_z;
        logic [SAMPLE_W-1:0] gyro_y;
        logic [SAMPLE_W-1:0] gyro_x;
        logic [SAMPLE_W-1:0] accel_z;
        logic [SAMPLE_W-1:0] accel_y;
        logic [SAMPLE_W-1:0] accel_x;
        logic [15:0]         time_fine;
        logic [31:0]         time_coarse;
    } t_sample;

    typedef struct packed {
        logic [SAMPLE_W-1:0] rate_out_z;
        logic [SAMPLE_W-1:0] rate_out_y;
        logic [SAMPLE_W-1:0] rate_out_x;
        logic [SAMPLE_W-1:0] acc_out_z;
        logic [SAMPLE_W-1:0] acc_out_y;
        logic [SAMPLE_W-1:0] acc_out_x;
        logic [15:0]         stamp_fine;
        logic [31:0]         stamp_coarse;
    } t_result;

endpackage

// File: rtl/imu_bias_calibrate_correct_unit.sv
// Top level of the IMU bias calibration and correction unit.
// Depends on imu_bcc_pkg, imu_bcc_cfg, imu_bcc_bias and imu_bcc_corr.
//
//   channel   direction  ports                             contents
//   sample    in         i_s_tvalid/o_s_tready/i_s_tdata   timestamp + 6 raw readings
//   result    out        o_m_tvalid/i_m_tready/o_m_tdata   timestamp + corrected readings
//   config    in         i_cfg_valid/o_cfg_ready/i_cfg_*   register index + write data
//
// One sample per cycle while the result side and the bias divide do not stall;
// each taken sample passes through the input register, then the result register.
// After the last calibration sample, the bias divide loads the magnitudes,
// does the reciprocal multiply and restores the sign; o_s_tready
// is low during that time. Samples taken while disabled are dropped.
// A stall on the result side backs up through the input register.
module imu_bias_calibrate_correct_unit #(
    parameter int unsigned CAL_SAMPLES = 100
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // time_coarse, time_fine, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [imu_bcc_pkg::TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // stamp_coarse, stamp_fine, acc_out_x/y/z, rate_out_x/y/z
    output logic [imu_bcc_pkg::TDATA_W-1:0]     o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [imu_bcc_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [imu_bcc_pkg::CFG_DW-1:0]      i_cfg_data
);
    import imu_bcc_pkg::*;

    t_cfg        cfg;
    t_cal_status cal;
    t_sample     sample;
    t_result     result;
    logic        corr_ready;
    logic        s_accept;
    logic        cal_add;
    logic        corr_load;

    logic [AXES-1:0][SAMPLE_W-1:0] gyro;
    logic [AXES-1:0][SAMPLE_W-1:0] bias;

    assign sample    = t_sample'(i_s_tdata);
    assign gyro      = '{sample.gyro_z, sample.gyro_y, sample.gyro_x};
    assign o_s_tready = !cal.busy && corr_ready;
    assign s_accept  = i_s_tvalid && o_s_tready;
    assign cal_add   = s_accept && cfg.enable && !cal.done;
    assign corr_load = s_accept && cfg.enable && cal.done;
    assign o_m_tdata = TDATA_W'(result);

    imu_bcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    imu_bcc_bias #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_bias (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_add    (cal_add),
        .i_gyro   (gyro),
        .o_bias   (bias),
        .o_status (cal)
    );

    imu_bcc_corr u_corr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (corr_load),
        .i_sample  (sample),
        .i_bias    (bias),
        .i_cfg     (cfg),
        .i_m_ready (i_m_tready),
        .o_ready   (corr_ready),
        .o_valid   (o_m_tvalid),
        .o_result  (result)
    );

endmodule

// File: rtl/imu_bcc_cfg.sv
// Configuration register file: enable, accel gains and offsets.
// Depends on imu_bcc_pkg.
module imu_bcc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [imu_bcc_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [imu_bcc_pkg::CFG_DW-1:0]      i_cfg_data,
    output logic                                o_cfg_ready,
    output imu_bcc_pkg::t_cfg                   o_cfg
);
    import imu_bcc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b0;
            r_cfg.gain[0]   <= GAIN_X_RST;
            r_cfg.gain[1]   <= GAIN_Y_RST;
            r_cfg.gain[2]   <= GAIN_Z_RST;
            r_cfg.offset[0] <= OFFSET_X_RST;
            r_cfg.offset[1] <= OFFSET_Y_RST;
            r_cfg.offset[2] <= OFFSET_Z_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ENABLE:   r_cfg.enable    <= i_cfg_data[0];
                REG_GAIN_X:   r_cfg.gain[0]   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_Y:   r_cfg.gain[1]   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_Z:   r_cfg.gain[2]   <= i_cfg_data[GAIN_W-1:0];
                REG_OFFSET_X: r_cfg.offset[0] <= i_cfg_data[OFFSET_W-1:0];
                REG_OFFSET_Y: r_cfg.offset[1] <= i_cfg_data[OFFSET_W-1:0];
                REG_OFFSET_Z: r_cfg.offset[2] <= i_cfg_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/imu_bcc_bias.sv
// Gyro bias calibration: per-axis sums over CAL_SAMPLES samples, then a
// divide by CAL_SAMPLES through a reciprocal multiply. Depends on imu_bcc_pkg.
module imu_bcc_bias #(
    parameter int unsigned CAL_SAMPLES = 100
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_add,
    input  logic [imu_bcc_pkg::AXES-1:0][imu_bcc_pkg::SAMPLE_W-1:0] i_gyro,
    output logic [imu_bcc_pkg::AXES-1:0][imu_bcc_pkg::SAMPLE_W-1:0] o_bias,
    output imu_bcc_pkg::t_cal_status                                o_status
);
    import imu_bcc_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);
    localparam int unsigned RECIP_W   = SUM_W + 1;
    localparam int unsigned PROD_W    = SUM_W + RECIP_W;
    localparam int unsigned DIV_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(1);

    t_cal_state                        r_state, n_state;
    logic [CNT_W-1:0]                  r_cnt;
    logic [STEP_W-1:0]                 r_step;
    logic [AXES-1:0][SUM_W-1:0]        r_sum;
    logic [AXES-1:0][SUM_W-1:0]        r_mag;
    logic [AXES-1:0]                   r_neg;

    logic [AXES-1:0][SUM_W-1:0]        n_quo;
    logic [AXES-1:0][SUM_W-1:0]        n_sum;
    logic [AXES-1:0][SUM_W-1:0]        abs_sum;

    always_comb begin
        n_state = r_state;
        case (r_state)
            CAL_ACCUM: if (i_add && r_cnt == CNT_LAST) n_state = CAL_LOAD;
            CAL_LOAD:  n_state = CAL_DIV;
            CAL_DIV:   if (r_step == STEP_LAST) n_state = CAL_DONE;
            CAL_DONE:  n_state = CAL_DONE;
            default:   n_state = CAL_ACCUM;
        endcase
    end

    always_comb begin
        o_status.busy = 1'b0;
        o_status.done = 1'b0;
        case (r_state)
            CAL_LOAD, CAL_DIV: o_status.busy = 1'b1;
            CAL_DONE:          o_status.done = 1'b1;
            default: begin
            end
        endcase
    end

    // magnitude quotient by reciprocal multiply, exact for magnitudes below 2**SUM_W
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            logic [PROD_W-1:0] prod;
            prod     = {{RECIP_W{1'b0}}, r_mag[i]} * {{SUM_W{1'b0}}, RECIP};
            n_quo[i] = SUM_W'(prod >> DIV_SHIFT);
            n_sum[i] = r_sum[i] + {{(SUM_W-SAMPLE_W){i_gyro[i][SAMPLE_W-1]}}, i_gyro[i]};
            abs_sum[i] = r_sum[i][SUM_W-1] ? (~r_sum[i] + 1'b1) : r_sum[i];
            o_bias[i] = r_sum[i][SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CAL_ACCUM;
            r_cnt   <= '0;
            r_step  <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                CAL_ACCUM: begin
                    if (i_add) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_sum <= n_sum;
                    end
                end
                CAL_LOAD: begin
                    r_step <= '0;
                    for (int i = 0; i < AXES; i++) begin
                        r_mag[i] <= abs_sum[i];
                        r_neg[i] <= r_sum[i][SUM_W-1];
                    end
                end
                CAL_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        for (int i = 0; i < AXES; i++) begin
                            r_sum[i] <= r_neg[i] ? (~r_mag[i] + 1'b1) : r_mag[i];
                        end
                    end else begin
                        r_mag <= n_quo;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/imu_bcc_corr.sv
// Correction datapath: input register, accel scale/offset with saturation,
// gyro bias removal, result register. Depends on imu_bcc_pkg.
module imu_bcc_corr (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    i_load,
    input  imu_bcc_pkg::t_sample                                    i_sample,
    input  logic [imu_bcc_pkg::AXES-1:0][imu_bcc_pkg::SAMPLE_W-1:0] i_bias,
    input  imu_bcc_pkg::t_cfg                                       i_cfg,
    input  logic                                                    i_m_ready,
    output logic                                                    o_ready,
    output logic                                                    o_valid,
    output imu_bcc_pkg::t_result                                    o_result
);
    import imu_bcc_pkg::*;

    logic    r_s1_v;
    t_sample r_s1;
    logic    r_out_v;
    t_result r_out;

    logic    s1_move;
    t_result n_out;

    logic [AXES-1:0][SAMPLE_W-1:0] acc_in;
    logic [AXES-1:0][SAMPLE_W-1:0] gyr_in;
    logic [AXES-1:0][SAMPLE_W-1:0] acc_res;
    logic [AXES-1:0][SAMPLE_W-1:0] gyr_res;

    assign s1_move  = r_s1_v && (!r_out_v || i_m_ready);
    assign o_ready  = !r_s1_v || s1_move;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    assign acc_in = '{r_s1.accel_z, r_s1.accel_y, r_s1.accel_x};
    assign gyr_in = '{r_s1.gyro_z, r_s1.gyro_y, r_s1.gyro_x};

    // (a*g - off*256) / 65536, truncated toward zero, then clamped
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            logic signed [SAMPLE_W-1:0] a;
            logic signed [GAIN_W:0]     g;
            logic signed [33:0]         prod;
            logic signed [33:0]         off_sh;
            logic signed [33:0]         diff;
            logic signed [33:0]         adj;
            logic        [17:0]         q;
            a      = signed'(acc_in[i]);
            g      = signed'({1'b0, i_cfg.gain[i]});
            prod   = a * g;
            off_sh = {{2{i_cfg.offset[i][OFFSET_W-1]}}, i_cfg.offset[i], 8'd0};
            diff   = prod - off_sh;
            adj    = diff + (diff[33] ? 34'sd65535 : 34'sd0);
            q      = adj[33:16];
            if (!q[17] && (q[16] || q[15])) begin
                acc_res[i] = 16'h7fff;
            end else if (q[17] && !(q[16] && q[15])) begin
                acc_res[i] = 16'h8000;
            end else begin
                acc_res[i] = q[15:0];
            end
            gyr_res[i] = gyr_in[i] - i_bias[i];
        end
    end

    always_comb begin
        n_out.stamp_coarse = r_s1.time_coarse;
        n_out.stamp_fine   = r_s1.time_fine;
        n_out.acc_out_x    = acc_res[0];
        n_out.acc_out_y    = acc_res[1];
        n_out.acc_out_z    = acc_res[2];
        n_out.rate_out_x   = gyr_res[0];
        n_out.rate_out_y   = gyr_res[1];
        n_out.rate_out_z   = gyr_res[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_out_v <= 1'b1;
            end else if (i_m_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_sample;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

endmodule
